>>> rtl/core/rgbconv_pkg.sv
// types, constants and helper functions shared by the rgb 3x3 convolution block
package rgbconv_pkg;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned GeomLimit    = 1024;
  localparam int unsigned LineDepth    = (MaxWidth < GeomLimit) ? MaxWidth : GeomLimit;
  localparam int unsigned ColW         = $clog2(LineDepth);
  localparam int unsigned RowW         = $clog2(GeomLimit);
  localparam int unsigned GeomW        = 11;
  localparam int unsigned NumBanks     = 3;
  localparam int unsigned BankW        = 2;
  localparam int unsigned PixW         = 24;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned CoefRowW     = 3 * CoefW;
  localparam int unsigned CoefFracBits = 12;
  localparam int unsigned ProdW        = CoefW + ChanW;
  localparam int unsigned AccW         = ProdW + 4;
  localparam int unsigned PixMax       = 255;
  localparam int unsigned AddrW        = 6;
  localparam int unsigned DataW        = 64;

  localparam logic [CoefRowW-1:0] CoefIdentityRow = 48'h0000_1000_0000;

  // register indexes
  localparam logic [2:0] RegWidth   = 3'd0;
  localparam logic [2:0] RegHeight  = 3'd1;
  localparam logic [2:0] RegCoefTop = 3'd2;
  localparam logic [2:0] RegCoefMid = 3'd3;
  localparam logic [2:0] RegCoefBot = 3'd4;

  typedef struct packed {
    logic             action;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [9:0]       out_row;
    logic [9:0]       out_column;
    logic             frame_end;
  } pix_out_t;

  function automatic logic [GeomW-1:0] clamp_geom(input logic [GeomW-1:0] v,
                                                  input logic [GeomW-1:0] lim);
    logic [GeomW-1:0] r;
    r = v;
    if (r == '0) r = GeomW'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

  function automatic logic [BankW-1:0] bank_next(input logic [BankW-1:0] b);
    return (b == BankW'(NumBanks - 1)) ? '0 : b + BankW'(1);
  endfunction

  function automatic logic [BankW-1:0] bank_prev(input logic [BankW-1:0] b);
    return (b == '0) ? BankW'(NumBanks - 1) : b - BankW'(1);
  endfunction

  function automatic logic signed [ProdW-1:0] mul_tap(input logic [CoefW-1:0] coef,
                                                      input logic [ChanW-1:0] chan);
    logic signed [ProdW:0] full;
    full = $signed(coef) * $signed({1'b0, chan});
    return full[ProdW-1:0];
  endfunction

  // truncate toward zero, then saturate to the pixel range
  function automatic logic [ChanW-1:0] clamp_pixel(input logic [AccW-1:0] acc);
    logic [AccW-1:0] sh;
    sh = acc >> CoefFracBits;
    if (acc[AccW-1] || (acc == '0)) return '0;
    if (sh > AccW'(PixMax)) return ChanW'(PixMax);
    return sh[ChanW-1:0];
  endfunction

endpackage

>>> rtl/core/rgb_3x3_convolution_clamp.sv
// top level of the rgb 3x3 zero padded convolution with clamp
//
// Pixels enter in raster order on the in channel (valid/ready); action low
// carries a pixel, action high is a drain that only pushes out one pending
// result. A filtered pixel is produced by the transaction that completes its
// neighbourhood, normally the pixel one row and one column further on; the
// last row is flushed with drains (or with pixels sent after the frame, which
// are dropped). Each input transaction gives zero or one result.
// A result passes the line store read, the tap products and the sum and
// clamp, each registered, to reach the out channel. Throughput is one
// transaction per cycle while input ready is high, set by the single
// write port and the per-row read ports of the three line banks.
// If the receiver stalls, up to three results sit in the pipe; input ready
// drops only once every stage holds a result.
// Reset loads a 1024 x 1024 geometry and an identity kernel and clears the
// counters; the line banks are not cleared. Writing width or height restarts
// the frame. The apb port has pready tied high and 64-bit registers at 8*i.
module rgb_3x3_convolution_clamp
  import rgbconv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pix_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // configuration
  logic [GeomW-1:0]                width_q, height_q;
  logic [2:0][CoefRowW-1:0]        coef_q;
  logic [GeomW-1:0]                width_eff, height_eff;
  logic                            cfg_wr, cfg_geom_wr;
  logic [2:0]                      cfg_idx;

  // frame counters
  logic [GeomW-1:0]                in_row_q, in_row_d;
  logic [ColW-1:0]                 in_col_q, in_col_d;
  logic [BankW-1:0]                in_bank_q, in_bank_d;
  logic [RowW-1:0]                 out_row_q, out_row_d;
  logic [ColW-1:0]                 out_col_q, out_col_d;
  logic [BankW-1:0]                out_bank_q, out_bank_d;

  logic                            in_fire, frame_full, store, emit, emit_last;
  logic [GeomW-1:0]                in_col_p1, rcv_row, rcv_col;
  logic [GeomW-1:0]                out_row_w, out_col_w, out_row_p1, out_col_p1;
  logic [GeomW-1:0]                need_row, need_col;
  logic [PixW-1:0]                 pix_wr;

  // line banks, one per row modulo three
  logic [PixW-1:0]                 line_mem [NumBanks][LineDepth];
  logic [NumBanks-1:0][PixW-1:0]   rd_right_q, rd_zero_q;
  logic [ColW-1:0]                 rd_addr;

  // pipeline
  logic                            s1_v_q, s2_v_q, out_v_q;
  logic                            s1_free, s2_free, s3_free;
  logic                            s1_rowstart_q, s1_right_ok_q, s1_top_ok_q, s1_bot_ok_q;
  logic                            s1_last_q, s2_last_q;
  logic [BankW-1:0]                s1_bank_q;
  logic [RowW-1:0]                 s1_row_q, s2_row_q;
  logic [ColW-1:0]                 s1_col_q, s2_col_q;
  logic [2:0][PixW-1:0]            win_c_q, win_r_q;
  logic [2:0][2:0][PixW-1:0]       cur_win;
  logic [2:0][BankW-1:0]           bsel;
  logic [2:0]                      row_ok;
  logic signed [ProdW-1:0]         prod_d [3][9];
  logic signed [ProdW-1:0]         prod_q [3][9];
  logic [2:0][ChanW-1:0]           chan_d;
  logic [AccW-1:0]                 acc;
  pix_out_t                        out_q;

  // ---------------------------------------------------------------------------
  // configuration port

  assign pready      = 1'b1;
  assign cfg_idx     = paddr[AddrW-1:3];
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_geom_wr = cfg_wr && ((cfg_idx == RegWidth) || (cfg_idx == RegHeight));

  always_comb begin
    case (cfg_idx)
      RegWidth:   prdata = DataW'(width_q);
      RegHeight:  prdata = DataW'(height_q);
      RegCoefTop: prdata = DataW'(coef_q[0]);
      RegCoefMid: prdata = DataW'(coef_q[1]);
      RegCoefBot: prdata = DataW'(coef_q[2]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= GeomW'(GeomLimit);
      height_q  <= GeomW'(GeomLimit);
      coef_q[0] <= '0;
      coef_q[1] <= CoefIdentityRow;
      coef_q[2] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegWidth:   width_q   <= pwdata[GeomW-1:0];
        RegHeight:  height_q  <= pwdata[GeomW-1:0];
        RegCoefTop: coef_q[0] <= pwdata[CoefRowW-1:0];
        RegCoefMid: coef_q[1] <= pwdata[CoefRowW-1:0];
        RegCoefBot: coef_q[2] <= pwdata[CoefRowW-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_geom(width_q, GeomW'(LineDepth));
  assign height_eff = clamp_geom(height_q, GeomW'(GeomLimit));

  // ---------------------------------------------------------------------------
  // input and output position tracking

  assign s3_free    = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_ready_o = s1_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign frame_full = in_row_q >= height_eff;
  assign store      = in_fire && !in_data_i.action && !frame_full;
  assign pix_wr     = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};

  assign out_row_w  = GeomW'(out_row_q);
  assign out_col_w  = GeomW'(out_col_q);
  assign out_row_p1 = out_row_w + GeomW'(1);
  assign out_col_p1 = out_col_w + GeomW'(1);
  assign in_col_p1  = GeomW'(in_col_q) + GeomW'(1);
  assign rd_addr    = out_col_p1[ColW-1:0];

  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_bank_d  = in_bank_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_bank_d = out_bank_q;

    if (store) begin
      if (in_col_p1 >= width_eff) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + GeomW'(1);
        in_bank_d = bank_next(in_bank_q);
      end else begin
        in_col_d  = in_col_p1[ColW-1:0];
      end
    end
    rcv_row = in_row_d;
    rcv_col = GeomW'(in_col_d);

    // the output is due once its lower right neighbour (clipped to the image) is in
    need_row  = (out_row_p1 < height_eff) ? out_row_p1 : out_row_w;
    need_col  = (out_col_p1 < width_eff) ? out_col_p1 : out_col_w;
    emit      = in_fire && ((need_row < rcv_row) ||
                            ((need_row == rcv_row) && (need_col < rcv_col)));
    emit_last = (out_row_p1 == height_eff) && (out_col_p1 == width_eff);

    if (emit) begin
      if (emit_last) begin
        in_row_d   = '0;
        in_col_d   = '0;
        in_bank_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_bank_d = '0;
      end else if (out_col_p1 == width_eff) begin
        out_col_d  = '0;
        out_row_d  = out_row_p1[RowW-1:0];
        out_bank_d = bank_next(out_bank_q);
      end else begin
        out_col_d  = out_col_p1[ColW-1:0];
      end
    end

    if (cfg_geom_wr) begin
      in_row_d   = '0;
      in_col_d   = '0;
      in_bank_d  = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_bank_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_bank_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_bank_q <= '0;
    end else begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_bank_q  <= in_bank_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_bank_q <= out_bank_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line banks: one write, reads of column c+1 and column 0 in every bank,
  // with the pixel written in the same cycle passed straight through

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NumBanks; b++) begin
      if (store && (in_bank_q == BankW'(b))) begin
        line_mem[b][in_col_q] <= pix_wr;
      end
      if (emit) begin
        rd_right_q[b] <= (store && (in_bank_q == BankW'(b)) && (in_col_q == rd_addr)) ?
                         pix_wr : line_mem[b][rd_addr];
        rd_zero_q[b]  <= (store && (in_bank_q == BankW'(b)) && (in_col_q == '0)) ?
                         pix_wr : line_mem[b][0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: line read data and window

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_rowstart_q <= (out_col_q == '0);
      s1_right_ok_q <= out_col_p1 < width_eff;
      s1_top_ok_q   <= (out_row_q != '0);
      s1_bot_ok_q   <= out_row_p1 < height_eff;
      s1_bank_q     <= out_bank_q;
      s1_row_q      <= out_row_q;
      s1_col_q      <= out_col_q;
      s1_last_q     <= emit_last;
    end
  end

  always_comb begin
    bsel[0]   = bank_prev(s1_bank_q);
    bsel[1]   = s1_bank_q;
    bsel[2]   = bank_next(s1_bank_q);
    row_ok[0] = s1_top_ok_q;
    row_ok[1] = 1'b1;
    row_ok[2] = s1_bot_ok_q;
    for (int k = 0; k < 3; k++) begin
      // a new row reloads the whole window, the left column being padding
      cur_win[k][0] = s1_rowstart_q ? '0 : win_c_q[k];
      cur_win[k][1] = s1_rowstart_q ? (row_ok[k] ? rd_zero_q[bsel[k]] : '0) : win_r_q[k];
      cur_win[k][2] = (row_ok[k] && s1_right_ok_q) ? rd_right_q[bsel[k]] : '0;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_d[ch][3*k+j] = mul_tap(coef_q[k][CoefW*j +: CoefW],
                                      cur_win[k][j][ChanW*(2-ch) +: ChanW]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: tap products

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_free) begin
      for (int k = 0; k < 3; k++) begin
        win_c_q[k] <= cur_win[k][1];
        win_r_q[k] <= cur_win[k][2];
      end
      for (int ch = 0; ch < 3; ch++) begin
        for (int t = 0; t < 9; t++) begin
          prod_q[ch][t] <= prod_d[ch][t];
        end
      end
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int t = 0; t < 9; t++) begin
        acc = acc + {{(AccW-ProdW){prod_q[ch][t][ProdW-1]}}, prod_q[ch][t]};
      end
      chan_d[ch] = clamp_pixel(acc);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: result register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s3_free) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_free) begin
      out_q.red_out    <= chan_d[0];
      out_q.green_out  <= chan_d[1];
      out_q.blue_out   <= chan_d[2];
      out_q.out_row    <= 10'(s2_row_q);
      out_q.out_column <= 10'(s2_col_q);
      out_q.frame_end  <= s2_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions

  // outputs never overtake the pixels received
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    GeomW'(out_row_q) <= in_row_q)
    else $error("output position ahead of input position");

  // input stays within two rows of the output, so the three banks never alias
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= GeomW'(out_row_q) + GeomW'(2))
    else $error("input ran too far ahead of output");

  // the last result of a frame restarts both sides
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last && !cfg_geom_wr) |=>
      (in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && out_col_q == '0))
    else $error("frame did not restart after last result");

  // frame end is flagged only at the bottom right corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |->
      ((GeomW'(out_data_o.out_row) == height_eff - GeomW'(1)) &&
       (GeomW'(out_data_o.out_column) == width_eff - GeomW'(1))))
    else $error("frame end away from last pixel");

endmodule

>>> tb/sv/rgb_3x3_convolution_clamp_tb.sv
// self-checking testbench for the rgb 3x3 zero padded convolution with clamp
module rgb_3x3_convolution_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbconv_pkg::*;

  localparam logic       ActPixel      = 1'b0;
  localparam logic       ActDrain      = 1'b1;
  localparam logic [2:0] RegSpareLow   = 3'd5;
  localparam logic [2:0] RegSpareHigh  = 3'd7;
  localparam int unsigned HistLen      = 4 * MaxWidth;
  localparam int unsigned RandomItems  = 850;
  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int          MaxReports   = 40;

  class filter_scoreboard;
    typedef struct {
      pix_out_t         pix;
      longint unsigned  stamp;
    } filtered_entry_t;

    logic [GeomW-1:0]    width_reg;
    logic [GeomW-1:0]    height_reg;
    logic [CoefRowW-1:0] coef_row [3];
    logic [PixW-1:0]     history [HistLen];
    int unsigned         in_col;
    int unsigned         in_row;
    int unsigned         out_pos;
    int unsigned         frames_done;
    int                  errors;
    filtered_entry_t     filtered_q [$];

    function new();
      width_reg   = GeomW'(1024);
      height_reg  = GeomW'(1024);
      coef_row[0] = '0;
      coef_row[1] = CoefIdentityRow;
      coef_row[2] = '0;
      foreach (history[i]) history[i] = '0;
      in_col      = 0;
      in_row      = 0;
      out_pos     = 0;
      frames_done = 0;
      errors      = 0;
    endfunction

    function int unsigned geom(logic [GeomW-1:0] v, int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_pos = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DataW-1:0] value);
      case (idx)
        RegWidth: begin
          width_reg = value[GeomW-1:0];
          restart();
        end
        RegHeight: begin
          height_reg = value[GeomW-1:0];
          restart();
        end
        RegCoefTop: coef_row[0] = value[CoefRowW-1:0];
        RegCoefMid: coef_row[1] = value[CoefRowW-1:0];
        RegCoefBot: coef_row[2] = value[CoefRowW-1:0];
        default: ;
      endcase
    endfunction

    function bit frame_received();
      return in_row >= geom(height_reg, GeomLimit);
    endfunction

    function int unsigned pending_count();
      return filtered_q.size();
    endfunction

    function logic [ChanW-1:0] saturate_channel(longint acc);
      if (acc <= 0) return '0;
      acc = acc >>> CoefFracBits;
      if (acc > PixMax) return ChanW'(PixMax);
      return acc[ChanW-1:0];
    endfunction

    // returns 1 when the transaction stored a pixel or produced a result
    function bit note_item(pix_in_t item);
      int unsigned     w, h, total, received, q, r, c, nr, nc, fr, fc, ki, kj;
      longint          acc_r, acc_g, acc_b, k;
      logic [PixW-1:0] px;
      filtered_entry_t e;
      bit              stored;
      w        = geom(width_reg, LineDepth);
      h        = geom(height_reg, GeomLimit);
      total    = w * h;
      received = (in_row >= h) ? total : in_row * w + in_col;
      stored   = (item.action == ActPixel) && (in_row < h);
      if (stored) begin
        history[received % HistLen] = {item.red_in, item.green_in, item.blue_in};
        received++;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      q = out_pos;
      if (q >= total) return stored;
      r  = q / w;
      c  = q % w;
      nr = (r + 1 > h - 1) ? h - 1 : r + 1;
      nc = (c + 1 > w - 1) ? w - 1 : c + 1;
      if (nr * w + nc >= received) return stored;
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      for (ki = 0; ki < 3; ki++) begin
        for (kj = 0; kj < 3; kj++) begin
          if (r + ki >= 1 && c + kj >= 1) begin
            fr = r + ki - 1;
            fc = c + kj - 1;
            if (fr < h && fc < w) begin
              px    = history[(fr * w + fc) % HistLen];
              k     = $signed(coef_row[ki][kj*CoefW +: CoefW]);
              acc_r += k * longint'(px[23:16]);
              acc_g += k * longint'(px[15:8]);
              acc_b += k * longint'(px[7:0]);
            end
          end
        end
      end
      e.pix.red_out    = saturate_channel(acc_r);
      e.pix.green_out  = saturate_channel(acc_g);
      e.pix.blue_out   = saturate_channel(acc_b);
      e.pix.out_row    = r[9:0];
      e.pix.out_column = c[9:0];
      e.pix.frame_end  = 1'b0;
      q++;
      if (q >= total) begin
        e.pix.frame_end = 1'b1;
        restart();
        frames_done++;
      end else begin
        out_pos = q;
      end
      e.stamp = $time;
      filtered_q.push_back(e);
      return 1'b1;
    endfunction

    function bit same_field(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      if (errors < MaxReports)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
    endfunction

    function void check_filtered(pix_out_t got);
      filtered_entry_t e;
      bit              ok;
      // a transaction noted at this very edge cannot have its result out yet
      if (filtered_q.size() == 0 || filtered_q[0].stamp >= $time) begin
        if (errors < MaxReports)
          $display("%0t ns: expected no result, got row %0d column %0d", $time,
                   got.out_row, got.out_column);
        errors++;
        return;
      end
      e  = filtered_q.pop_front();
      ok = same_field("red_out", e.pix.red_out, got.red_out) &
           same_field("green_out", e.pix.green_out, got.green_out) &
           same_field("blue_out", e.pix.blue_out, got.blue_out) &
           same_field("out_row", e.pix.out_row, got.out_row) &
           same_field("out_column", e.pix.out_column, got.out_column) &
           same_field("frame_end", e.pix.frame_end, got.frame_end);
      if (!ok) errors++;
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  pix_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pix_out_t         out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  bit               in_idle_en  = 1'b1;
  bit               out_idle_en = 1'b1;
  filter_scoreboard sb = new();

  rgb_3x3_convolution_clamp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(bit en);
    return en ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic [ChanW-1:0] rand_chan();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h1000;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hF000;
      5: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  // upper bits of the bus carry junk that the register must drop
  function automatic logic [DataW-1:0] coef_word(logic [15:0] left, logic [15:0] center,
                                                 logic [15:0] right);
    return {16'($urandom), right, center, left};
  endfunction

  function automatic logic [DataW-1:0] geom_word(logic [GeomW-1:0] g);
    logic [DataW-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1) != 0) junk = '0;
    return {junk[DataW-GeomW-1:0], g};
  endfunction

  function automatic pix_in_t next_item();
    pix_in_t item;
    if (sb.frame_received())
      item.action = ($urandom_range(0, 3) != 0) ? ActDrain : ActPixel;
    else
      item.action = ($urandom_range(0, 12) == 0) ? ActDrain : ActPixel;
    item.red_in   = rand_chan();
    item.green_in = rand_chan();
    item.blue_in  = rand_chan();
    return item;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic write_coefs();
    apb_write(RegCoefTop, coef_word(rand_coef(), rand_coef(), rand_coef()));
    apb_write(RegCoefMid, coef_word(rand_coef(), rand_coef(), rand_coef()));
    apb_write(RegCoefBot, coef_word(rand_coef(), rand_coef(), rand_coef()));
  endtask

  task automatic send_item(input pix_in_t item, output bit counted);
    int unsigned gap;
    gap = draw_gap(in_idle_en);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    counted = sb.note_item(item);
  endtask

  task automatic push(input logic act, input logic [PixW-1:0] rgb);
    pix_in_t item;
    bit      unused;
    item = {act, rgb};
    send_item(item, unused);
  endtask

  task automatic stream_frames(input int unsigned nframes, input int unsigned abort_at,
                               output int unsigned effective);
    int unsigned target, sent;
    bit          counted;
    target    = sb.frames_done + nframes;
    sent      = 0;
    effective = 0;
    while (sb.frames_done < target && (abort_at == 0 || sent < abort_at)) begin
      send_item(next_item(), counted);
      sent++;
      if (counted) effective++;
    end
  endtask

  // registers only change once the pipe has emptied
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic accept_results();
    int unsigned gap;
    forever begin
      gap = draw_gap(out_idle_en);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_filtered(out_data);
    end
  endtask

  initial accept_results();

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL rgb_3x3_convolution_clamp");
    $finish;
  end

  initial begin : stimulus
    logic [GeomW-1:0] w_sel, h_sel;
    int unsigned      counted, eff, target, phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // partial frame at the reset geometry, then a restart by a geometry write
    push(ActPixel, 24'h000000);
    push(ActPixel, 24'hFFFFFF);
    push(ActPixel, 24'($urandom));
    push(ActDrain, 24'($urandom));
    wait_idle();

    // 3x2 frame through the reset kernel, flushed by drains
    apb_write(RegWidth, geom_word(11'd3));
    apb_write(RegHeight, geom_word(11'd2));
    push(ActPixel, 24'hFFFFFF);
    push(ActPixel, 24'h000000);
    push(ActPixel, 24'hFF00FF);
    push(ActPixel, 24'h00FF00);
    push(ActPixel, 24'h80807F);
    push(ActPixel, 24'hFFFFFF);
    target = sb.frames_done + 1;
    while (sb.frames_done < target) push(ActDrain, 24'($urandom));
    wait_idle();

    // zero geometry clamps to 1x1; outer taps must not contribute
    apb_write(RegWidth, geom_word(11'd0));
    apb_write(RegHeight, geom_word(11'd0));
    apb_write(RegCoefTop, coef_word(16'h8000, 16'h8000, 16'h8000));
    apb_write(RegCoefMid, coef_word(16'h7FFF, 16'h0FFF, 16'h7FFF));
    apb_write(RegCoefBot, coef_word(16'h7FFF, 16'h7FFF, 16'h7FFF));
    push(ActPixel, 24'hFF8001);
    push(ActDrain, 24'($urandom));
    push(ActPixel, 24'hFEFDFC);
    wait_idle();

    // 2x2 frame with extreme taps; pixels after the frame act as drains
    apb_write(RegWidth, geom_word(11'd2));
    apb_write(RegHeight, geom_word(11'd2));
    apb_write(RegCoefTop, coef_word(16'h7FFF, 16'h7FFF, 16'h7FFF));
    apb_write(RegCoefMid, coef_word(16'h8000, 16'h1000, 16'h8000));
    apb_write(RegCoefBot, coef_word(16'hFFFF, 16'h0000, 16'h0001));
    apb_write(RegSpareLow, {$urandom, $urandom});
    apb_write(RegSpareHigh, {$urandom, $urandom});
    push(ActPixel, 24'hFFFFFF);
    push(ActPixel, 24'h0000FF);
    push(ActPixel, 24'h00FF00);
    push(ActPixel, 24'hFF0000);
    push(ActPixel, 24'h123456);
    push(ActDrain, 24'($urandom));
    push(ActPixel, 24'hABCDEF);
    push(ActDrain, 24'($urandom));

    counted = 0;
    phase   = 0;
    while (counted < RandomItems) begin
      wait_idle();
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: begin
            w_sel = 11'($urandom_range(1, 3));
            h_sel = 11'($urandom_range(1, 3));
          end
          7, 8: begin
            w_sel = 11'($urandom_range(9, 24));
            h_sel = 11'($urandom_range(1, 6));
          end
          9: begin
            w_sel = ($urandom_range(0, 1) != 0) ? 11'd0 : 11'($urandom_range(1, 6));
            h_sel = (w_sel == '0) ? 11'($urandom_range(1, 5)) : 11'd0;
          end
          default: begin
            w_sel = 11'($urandom_range(1, 8));
            h_sel = 11'($urandom_range(1, 6));
          end
        endcase
        apb_write(RegWidth, geom_word(w_sel));
        apb_write(RegHeight, geom_word(h_sel));
      end
      // a coefficient-only change lets an interrupted frame carry on
      if ($urandom_range(0, 9) < 7) write_coefs();
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      stream_frames($urandom_range(1, 2),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : 0, eff);
      counted += eff;
      phase++;
    end

    // full line depth and full height, a few frames only
    wait_idle();
    apb_write(RegWidth, geom_word(11'd1024));
    apb_write(RegHeight, geom_word(11'd2));
    write_coefs();
    stream_frames(1, 0, eff);
    wait_idle();
    apb_write(RegWidth, geom_word(11'd1));
    apb_write(RegHeight, geom_word(11'd2047));
    write_coefs();
    stream_frames(1, 0, eff);
    wait_idle();
    apb_write(RegWidth, geom_word(11'd2047));
    apb_write(RegHeight, geom_word(11'd1));
    write_coefs();
    stream_frames(1, 0, eff);

    wait_idle();
    if (sb.errors == 0)
      $display("PASS rgb_3x3_convolution_clamp");
    else
      $display("FAIL rgb_3x3_convolution_clamp");
    $finish;
  end

endmodule

>>> rgb_3x3_convolution_clamp.f
rtl/core/rgbconv_pkg.sv
rtl/core/rgb_3x3_convolution_clamp.sv
tb/sv/rgb_3x3_convolution_clamp_tb.sv
